[hdl/rgbpse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rgbpse_pkg;

  localparam int unsigned CharWidth    = 8;
  localparam int unsigned GroupCount   = 4;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrW    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCountW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] CHAR_OFFSET      = 8'd33;
  localparam logic [7:0] ASCII_QUOTE      = 8'h22;
  localparam logic [7:0] ASCII_BACKSLASH  = 8'h5C;
  localparam logic [7:0] ASCII_NEWLINE    = 8'h0A;
  localparam logic [7:0] ASCII_TAB        = 8'h09;
  localparam logic [7:0] DEFAULT_PIX_LINE = 8'd16;

  // one classified pixel: its four printable characters and the line break flag
  typedef struct packed {
    logic [GroupCount-1:0][CharWidth-1:0] chars;
    logic                                 line_break;
  } pix_desc_t;

  // bytes of the line break sequence, in emission order
  function automatic logic [7:0] line_break_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = ASCII_QUOTE;
      2'd1:    b = ASCII_NEWLINE;
      2'd2:    b = ASCII_TAB;
      default: b = ASCII_QUOTE;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[hdl/rgbpse_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module rgbpse_front
  import rgbpse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_pixels_per_line,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  input  wire logic       q_full,
  output logic            push_valid,
  output pix_desc_t       push_desc
);

  logic [7:0] pixels_per_line_r, pixels_per_line_nxt;
  logic [7:0] line_count_r, line_count_nxt;
  logic       accept;
  logic [8:0] count_inc;
  logic       line_end;
  logic [GroupCount-1:0][5:0] groups;

  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign push_valid = accept;

  // msb first over red:green:blue
  assign groups[0] = in_red[7:2];
  assign groups[1] = {in_red[1:0], in_green[7:4]};
  assign groups[2] = {in_green[3:0], in_blue[7:6]};
  assign groups[3] = in_blue[5:0];

  assign count_inc = {1'b0, line_count_r} + 9'd1;
  assign line_end  = count_inc >= {1'b0, pixels_per_line_r};

  always_comb begin
    for (int g = 0; g < GroupCount; g++) begin
      push_desc.chars[g] = {2'b00, groups[g]} + CHAR_OFFSET;
    end
    push_desc.line_break = line_end;
  end

  always_comb begin
    pixels_per_line_nxt = cfg_valid ? cfg_pixels_per_line : pixels_per_line_r;
    line_count_nxt      = line_count_r;
    if (accept) begin
      line_count_nxt = line_end ? 8'd0 : count_inc[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_per_line_r <= DEFAULT_PIX_LINE;
      line_count_r      <= 8'd0;
    end else begin
      pixels_per_line_r <= pixels_per_line_nxt;
      line_count_r      <= line_count_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/rgbpse_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module rgbpse_queue
  import rgbpse_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  input  wire pix_desc_t push_desc,
  output logic           full,
  input  wire logic      pop,
  output logic           empty,
  output pix_desc_t      head
);

  pix_desc_t               mem_r [QueueDepth];
  logic [QueuePtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QueuePtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QueueCountW-1:0]  count_r, count_nxt;
  logic                    do_push, do_pop;

  assign full    = count_r == QueueCountW'(QueueDepth);
  assign empty   = count_r == '0;
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule
`default_nettype wire

[hdl/rgbpse_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module rgbpse_back
  import rgbpse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  wire pix_desc_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last_of_pixel
);

  logic       in_lb_r, in_lb_nxt;
  logic [1:0] step_r, step_nxt;
  logic       sub_r, sub_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;

  logic       load;
  logic [7:0] cur_char;
  logic       escape;
  logic       is_final;

  assign load     = !q_empty && (!out_valid_r || !out_stall);
  assign cur_char = q_head.chars[step_r];
  assign escape   = (cur_char == ASCII_QUOTE) || (cur_char == ASCII_BACKSLASH);

  always_comb begin
    in_lb_nxt     = in_lb_r;
    step_nxt      = step_r;
    sub_nxt       = sub_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    is_final      = 1'b0;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;

    if (in_lb_r) begin
      byte_nxt = line_break_byte(step_r);
      is_final = step_r == 2'd3;
    end else begin
      // escaped characters go out as a backslash followed by the character
      byte_nxt = (escape && !sub_r) ? ASCII_BACKSLASH : cur_char;
      is_final = (!escape || sub_r) && (step_r == 2'd3) && !q_head.line_break;
    end

    if (load) begin
      out_valid_nxt = 1'b1;
      last_nxt      = is_final;
      if (in_lb_r) begin
        step_nxt  = step_r + 2'd1;
        in_lb_nxt = !is_final;
      end else if (escape && !sub_r) begin
        sub_nxt = 1'b1;
      end else begin
        sub_nxt  = 1'b0;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          in_lb_nxt = q_head.line_break;
        end
      end
    end else begin
      byte_nxt = byte_r;
    end
  end

  assign q_pop             = load && is_final;
  assign out_valid         = out_valid_r;
  assign out_byte          = byte_r;
  assign out_last_of_pixel = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_lb_r     <= 1'b0;
      step_r      <= 2'd0;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_lb_r     <= in_lb_nxt;
      step_r      <= step_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

endmodule
`default_nettype wire

[hdl/rgb_printable_six_bit_encoder_core.sv]
// six-bit printable encoder for rgb pixels
// input channel: in_valid / in_stall with in_red, in_green, in_blue; an item is
//   taken at a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with out_byte and out_last_of_pixel,
//   one text byte per item; out_last_of_pixel marks the final byte of a pixel
// config channel: cfg_valid / cfg_ready with cfg_pixels_per_line; cfg_ready is
//   always high, write only while the block is idle
// each pixel gives 4 to 8 data bytes, plus the 4-byte line break when the line fills
// a pixel taken while the queue is empty is written into the queue, then its first
//   byte is loaded into the output register
// throughput: one output byte per cycle while out_stall is low and the queue is
//   not empty, set by the output register; a pixel gives 4 to 12 bytes
// a two-entry queue between the classifying front and the byte serializer lets
//   the next pixel be taken while the current one is still being emitted
// reset (rst_n low, synchronous) empties the queue, drops any pending byte,
//   clears the line count and sets pixels_per_line to 16
// when out_stall is high the pending byte holds; once the queue fills in_stall rises
`timescale 1ns / 1ps
`default_nettype none
module rgb_printable_six_bit_encoder_core
  import rgbpse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_pixels_per_line,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last_of_pixel
);

  pix_desc_t push_desc;
  pix_desc_t q_head;
  logic      push_valid;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // front: takes pixels, forms the four characters, decides line breaks
  rgbpse_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_pixels_per_line (cfg_pixels_per_line),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_red              (in_red),
    .in_green            (in_green),
    .in_blue             (in_blue),
    .q_full              (q_full),
    .push_valid          (push_valid),
    .push_desc           (push_desc)
  );

  // decoupling queue between front and back
  rgbpse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // back: walks the characters with escapes, then the line break bytes
  rgbpse_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_of_pixel (out_last_of_pixel)
  );

endmodule
`default_nettype wire
